// ===== rtl/glcc_pkg.sv =====
// ---------------------------------------------------------------------------
// glcc_pkg
// Shared types and constants for the grid longest-chain column update block.
// ---------------------------------------------------------------------------
package glcc_pkg;

	// Fixed field widths.
	localparam int ROWS_MAX     = 64;
	localparam int LEN_W        = 7;
	localparam int CNT_W        = 7;

	// Rows handled by one lane.
	localparam int LANE_ROWS    = 8;

	// Default row count and reset value of the row-count register.
	localparam int ROWS_DEFAULT = 64;
	localparam logic [CNT_W-1:0] ROWS_IN_USE_RESET = 7'd64;

	typedef logic [LEN_W-1:0] len_t;

	// Control from the sequencer to every lane.
	typedef struct packed {
		logic clear;    // clear all stored chain lengths
		logic cap_max;  // capture the lane's local maximum of old lengths
		logic update;   // apply the column to the lane's rows
	} lane_ctrl_t;

	// Control from the sequencer to the merging stage.
	typedef struct packed {
		logic clear;       // clear the best length
		logic load_carry;  // register the per-lane carry-in values
		logic load_best;   // fold the lane results into the best length
	} merge_ctrl_t;

endpackage

// ===== rtl/glcc_lane.sv =====
// ---------------------------------------------------------------------------
// glcc_lane
// One lane: holds the chain lengths of a group of consecutive rows, finds
// their maximum, and applies one column to them given the carry from below.
// ---------------------------------------------------------------------------
module glcc_lane
	import glcc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  lane_ctrl_t           ctrl,
	input  logic [LANE_ROWS-1:0] row_open,
	input  len_t                 carry_in,
	output len_t                 lane_max,
	output len_t                 lane_best
);

	len_t len_q [LANE_ROWS];
	len_t nxt_len [LANE_ROWS];
	len_t local_max;
	len_t prefix;
	len_t cand;
	len_t best_acc;
	len_t lane_max_q;
	len_t lane_best_q;

	// Maximum of the stored lengths of this lane.
	always_comb begin
		local_max = '0;
		for (int r = 0; r < LANE_ROWS; r++) begin
			if (len_q[r] > local_max) begin
				local_max = len_q[r];
			end
		end
	end

	// Running prefix maximum across the lane, starting from the carry of the
	// lanes below. Open rows take one more than the prefix if that is longer.
	always_comb begin
		prefix   = carry_in;
		best_acc = '0;
		cand     = '0;
		for (int r = 0; r < LANE_ROWS; r++) begin
			nxt_len[r] = len_q[r];
			if (row_open[r]) begin
				cand = prefix + LEN_W'(1);
				if (cand > len_q[r]) begin
					nxt_len[r] = cand;
				end
				if (nxt_len[r] > best_acc) begin
					best_acc = nxt_len[r];
				end
			end
			if (len_q[r] > prefix) begin
				prefix = len_q[r];
			end
		end
	end

	// Stored chain lengths.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < LANE_ROWS; r++) begin
				len_q[r] <= '0;
			end
		end else if (ctrl.clear) begin
			for (int r = 0; r < LANE_ROWS; r++) begin
				len_q[r] <= '0;
			end
		end else if (ctrl.update) begin
			for (int r = 0; r < LANE_ROWS; r++) begin
				len_q[r] <= nxt_len[r];
			end
		end
	end

	// Lane results for the merging stage.
	always_ff @(posedge clk) begin
		if (ctrl.cap_max) begin
			lane_max_q <= local_max;
		end
		if (ctrl.update) begin
			lane_best_q <= best_acc;
		end
	end

	assign lane_max  = lane_max_q;
	assign lane_best = lane_best_q;

endmodule

// ===== rtl/glcc_merge.sv =====
// ---------------------------------------------------------------------------
// glcc_merge
// Merging stage: turns the lane maxima into a carry for each lane and folds
// the lane results into the best chain length of the trial.
// ---------------------------------------------------------------------------
module glcc_merge
	import glcc_pkg::*;
#(
	parameter int LANES = (ROWS_DEFAULT + LANE_ROWS - 1) / LANE_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  merge_ctrl_t ctrl,
	input  len_t        lane_max [LANES],
	input  len_t        lane_best [LANES],
	output len_t        carry [LANES],
	output len_t        best_len
);

	len_t carry_q [LANES];
	len_t carry_nxt [LANES];
	len_t run;
	len_t best_q;
	len_t best_nxt;

	// Exclusive prefix maximum over the lanes: each lane sees the maximum
	// of all lanes below it.
	always_comb begin
		run = '0;
		for (int l = 0; l < LANES; l++) begin
			carry_nxt[l] = run;
			if (lane_max[l] > run) begin
				run = lane_max[l];
			end
		end
	end

	// New best length over the previous best and all lane results.
	always_comb begin
		best_nxt = best_q;
		for (int l = 0; l < LANES; l++) begin
			if (lane_best[l] > best_nxt) begin
				best_nxt = lane_best[l];
			end
		end
	end

	// Carry registers.
	always_ff @(posedge clk) begin
		if (ctrl.load_carry) begin
			for (int l = 0; l < LANES; l++) begin
				carry_q[l] <= carry_nxt[l];
			end
		end
	end

	// Best length of the current trial.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (ctrl.clear) begin
			best_q <= '0;
		end else if (ctrl.load_best) begin
			best_q <= best_nxt;
		end
	end

	assign carry    = carry_q;
	assign best_len = best_q;

endmodule

// ===== rtl/grid_longest_chain_column_update_top.sv =====
// ---------------------------------------------------------------------------
// grid_longest_chain_column_update_top
// Longest strictly increasing chain over grid columns, one column a request.
// ---------------------------------------------------------------------------
// Each request carries one grid column as a mask of open rows; the block
// updates the longest chain ending at every row and returns the best chain
// length of the current trial. The rows are split into lanes of eight that
// work side by side; a sequence of six steps handles one column
// (accept, lane maxima, carry merge, lane update, best merge, result), so a
// new request is taken only after the previous column has passed every step,
// and the result step waits until the previous result is taken. Set new_trial
// to clear all lengths before the column. rows_in_use may only be written
// while the block is idle; values above ROWS act as ROWS.
module grid_longest_chain_column_update_top
	import glcc_pkg::*;
#(
	parameter int ROWS = ROWS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ROWS_MAX-1:0] open_rows,
	input  logic                new_trial,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [LEN_W-1:0]    longest_chain,
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_wdata
);

	localparam int LANES = (ROWS + LANE_ROWS - 1) / LANE_ROWS;
	localparam int PAD   = LANES * LANE_ROWS;
	localparam logic [CNT_W-1:0] ROWS_C = CNT_W'(ROWS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LMAX,
		ST_CARRY,
		ST_UPDATE,
		ST_BEST,
		ST_OUT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] rows_in_use_q;
	logic [CNT_W-1:0] limit;
	logic [PAD-1:0]   open_pad;
	logic [PAD-1:0]   open_q;
	logic             accept;
	logic             out_load;
	logic             out_valid_q;
	len_t             longest_chain_q;
	lane_ctrl_t       lane_ctrl;
	merge_ctrl_t      merge_ctrl;
	len_t             lane_max_w [LANES];
	len_t             lane_best_w [LANES];
	len_t             carry_w [LANES];
	len_t             best_len;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q <= ROWS_IN_USE_RESET;
		end else if (cfg_we) begin
			rows_in_use_q <= cfg_wdata;
		end
	end

	// Effective row count.
	assign limit = (rows_in_use_q > ROWS_C) ? ROWS_C : rows_in_use_q;

	// Open rows limited to the rows in use; rows past ROWS in the last lane
	// never open.
	for (genvar y = 0; y < PAD; y++) begin : g_mask
		if (y < ROWS) begin : g_row
			assign open_pad[y] = open_rows[y] & (CNT_W'(y) < limit);
		end else begin : g_pad
			assign open_pad[y] = 1'b0;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// Control to the lanes and the merging stage.
	always_comb begin
		lane_ctrl.clear        = accept && new_trial;
		lane_ctrl.cap_max      = (state_q == ST_LMAX);
		lane_ctrl.update       = (state_q == ST_UPDATE);
		merge_ctrl.clear       = accept && new_trial;
		merge_ctrl.load_carry  = (state_q == ST_CARRY);
		merge_ctrl.load_best   = (state_q == ST_BEST);
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LMAX;
					end
				end
				ST_LMAX:   state_q <= ST_CARRY;
				ST_CARRY:  state_q <= ST_UPDATE;
				ST_UPDATE: state_q <= ST_BEST;
				ST_BEST:   state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// Column and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			open_q <= open_pad;
		end
		if (out_load) begin
			longest_chain_q <= best_len;
		end
	end

	// Lanes.
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		glcc_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (lane_ctrl),
			.row_open  (open_q[l*LANE_ROWS +: LANE_ROWS]),
			.carry_in  (carry_w[l]),
			.lane_max  (lane_max_w[l]),
			.lane_best (lane_best_w[l])
		);
	end

	glcc_merge #(
		.LANES (LANES)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (merge_ctrl),
		.lane_max  (lane_max_w),
		.lane_best (lane_best_w),
		.carry     (carry_w),
		.best_len  (best_len)
	);

	assign out_valid     = out_valid_q;
	assign longest_chain = longest_chain_q;

	// The best length can never exceed the row count.
	a_best_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (longest_chain <= ROWS_C))
		else $error("longest_chain above row count");

	// A new trial clears the best length.
	a_trial_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && new_trial) |=> (best_len == '0))
		else $error("best length not cleared by new trial");

	// Within a trial the best length never decreases.
	a_best_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && new_trial) |=> (best_len >= $past(best_len)))
		else $error("best length decreased within a trial");

	// A result is presented right after the result stage hands it over.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid && (longest_chain == $past(best_len))))
		else $error("result not presented after load");

endmodule
